// File: src/sbc_pkg.sv
// Package for the sphere/box contact block: shared widths, constants and flag types.
// Depends on nothing; every other source file imports it.
`default_nettype none

package sbc_pkg;

    localparam int AX_W   = 16;      // Q1.14 axis component
    localparam int HALF_W = 21;      // Q9.12 half size and radius
    localparam int LOC_W  = 22;      // clamped local coordinate, signed
    localparam int LEN_W  = 23;      // offset length and component magnitudes
    localparam int SS_W   = 46;      // sum of squares
    localparam int QUO_W  = 15;      // normal quotient
    localparam int DEP_W  = 22;      // depth
    localparam int NRM_W  = 16;      // normal component

    localparam int Q14_ONE = 16384;
    localparam int R_LIMIT = 4194304;

    typedef struct packed {
        logic border;   // at least one projection was clamped: centre outside
        logic far;      // offset too long for any radius to reach
    } t_flags;

endpackage

`default_nettype wire

// File: src/sbc_front.sv
// Front pipeline: offset, projection onto the box axes, clamping, face choice,
// rotation back and sum of squares, in seven register stages. Uses sbc_pkg.
`default_nettype none

module sbc_front #(
    parameter int CW = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [CW-1:0]          i_sc [3],
    input  logic signed [CW-1:0]          i_bc [3],
    input  logic [sbc_pkg::HALF_W-1:0]    i_radius,
    input  logic [47:0]                   i_ax [3],
    input  logic [62:0]                   i_half,
    output logic                          o_vld,
    output logic [sbc_pkg::SS_W-1:0]      o_ss,
    output sbc_pkg::t_flags               o_flags,
    output logic [sbc_pkg::LEN_W-1:0]     o_rabs [3],
    output logic [2:0]                    o_rneg,
    output logic signed [CW-1:0]          o_pos [3],
    output logic signed [sbc_pkg::NRM_W-1:0] o_nrm [3],
    output logic [sbc_pkg::DEP_W-1:0]     o_dep,
    output logic [sbc_pkg::HALF_W-1:0]    o_radius
);
    import sbc_pkg::*;

    localparam int RW = (CW + 2 > 27) ? CW + 2 : 27;
    localparam logic signed [RW-1:0] CMAX = RW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] CMIN = -CMAX - RW'(1);

    typedef struct packed {
        logic [2:0][CW:0]          p;
        logic [2:0][CW-1:0]        sc;
        logic [2:0][CW-1:0]        bc;
        logic [2:0][2:0][AX_W-1:0] ax;
        logic [2:0][HALF_W-1:0]    h;
        logic [HALF_W-1:0]         rad;
    } t_carry;

    typedef struct packed {
        t_flags                    flags;
        logic [2:0]                rneg;
        logic [2:0][LEN_W-1:0]     rabs;
        logic [2:0][CW-1:0]        pos;
        logic [2:0][NRM_W-1:0]     nrm;
        logic [DEP_W-1:0]          dep;
    } t_res;

    logic   [6:0]                r_v;
    t_carry                      r_c [7];
    t_carry                      n_c0;
    logic signed [CW+16:0]       r1_m [3][3];
    logic signed [LOC_W-1:0]     r2_loc [3];
    logic signed [LOC_W-1:0]     n_loc [3];
    logic                        r2_border;
    logic                        n_border;
    logic signed [37:0]          r3_qm [3][3];
    t_res                        r_rs [3:6];
    t_res                        n_rs3;
    t_res                        n_rs4;
    logic [SS_W-1:0]             r5_sq [3];
    logic [SS_W-1:0]             r6_ss;

    // Stage 0 input
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_c0.p[c]  = (CW + 1)'(i_sc[c]) - (CW + 1)'(i_bc[c]);
            n_c0.sc[c] = i_sc[c];
            n_c0.bc[c] = i_bc[c];
            n_c0.h[c]  = i_half[HALF_W*c +: HALF_W];
            for (int k = 0; k < 3; k++) begin
                n_c0.ax[c][k] = i_ax[c][AX_W*k +: AX_W];
            end
        end
        n_c0.rad = i_radius;
    end

    // Stage 2: sum, round and clamp the projections
    always_comb begin
        logic signed [CW+18:0] acc;
        logic signed [CW+18:0] tmp;
        logic signed [39:0]    rx;
        logic signed [39:0]    hx;
        n_border = 1'b0;
        for (int i = 0; i < 3; i++) begin
            acc = (CW + 19)'(r1_m[i][0]) + (CW + 19)'(r1_m[i][1]) + (CW + 19)'(r1_m[i][2]);
            tmp = acc + (CW + 19)'(8192);
            rx  = 40'($signed(tmp[CW+18:14]));
            hx  = 40'(r_c[1].h[i]);
            if (rx < -hx) begin
                rx = -hx;
                n_border = 1'b1;
            end
            if (rx > hx) begin
                rx = hx;
                n_border = 1'b1;
            end
            n_loc[i] = rx[LOC_W-1:0];
        end
    end

    // Stage 3: shallowest face for the inside case
    always_comb begin
        logic [HALF_W-1:0]   d [3];
        logic [HALF_W-1:0]   best;
        logic [1:0]          k;
        logic [LOC_W-1:0]    a;
        logic signed [16:0]  n;
        for (int i = 0; i < 3; i++) begin
            a    = r2_loc[i] < 0 ? LOC_W'(-r2_loc[i]) : LOC_W'(r2_loc[i]);
            d[i] = r_c[2].h[i] - a[HALF_W-1:0];
        end
        best = d[0];
        k    = 2'd0;
        if (d[1] < best) begin
            best = d[1];
            k    = 2'd1;
        end
        if (d[2] < best) begin
            best = d[2];
            k    = 2'd2;
        end
        n_rs3 = '0;
        n_rs3.flags.border = r2_border;
        for (int c = 0; c < 3; c++) begin
            n = 17'($signed(r_c[2].ax[k][c]));
            if (!(r2_loc[k] > 0)) n = -n;
            if (n > 17'sd16384) n = 17'sd16384;
            if (n < -17'sd16384) n = -17'sd16384;
            n_rs3.nrm[c] = n[NRM_W-1:0];
        end
        n_rs3.dep = DEP_W'(best) + DEP_W'(r_c[2].rad);
    end

    // Stage 4: rotate back, offset from the clamped point, contact position
    always_comb begin
        logic signed [39:0]   qs;
        logic signed [25:0]   q;
        logic signed [RW-1:0] rr;
        logic signed [RW-1:0] ra;
        logic signed [RW-1:0] qb;
        n_rs4 = r_rs[3];
        n_rs4.flags.far = 1'b0;
        for (int c = 0; c < 3; c++) begin
            qs = 40'(r3_qm[c][0]) + 40'(r3_qm[c][1]) + 40'(r3_qm[c][2]) + 40'sd8192;
            q  = $signed(qs[39:14]);
            rr = RW'($signed(r_c[3].p[c])) - RW'(q);
            if (rr > RW'(R_LIMIT) || rr < -RW'(R_LIMIT)) n_rs4.flags.far = 1'b1;
            ra = rr < 0 ? -rr : rr;
            n_rs4.rneg[c] = rr < 0;
            n_rs4.rabs[c] = ra[LEN_W-1:0];
            qb = RW'(q) + RW'($signed(r_c[3].bc[c]));
            if (!r_rs[3].flags.border) n_rs4.pos[c] = r_c[3].sc[c];
            else if (qb > CMAX)        n_rs4.pos[c] = CMAX[CW-1:0];
            else if (qb < CMIN)        n_rs4.pos[c] = CMIN[CW-1:0];
            else                       n_rs4.pos[c] = qb[CW-1:0];
        end
        if (n_rs4.flags.far) n_rs4.rabs = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c[0] <= n_c0;
            for (int s = 1; s < 7; s++) r_c[s] <= r_c[s-1];
            for (int i = 0; i < 3; i++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_m[i][c]  <= $signed(r_c[0].p[c]) * $signed(r_c[0].ax[i][c]);
                    r3_qm[c][i] <= r2_loc[i] * $signed(r_c[2].ax[i][c]);
                end
                r2_loc[i] <= n_loc[i];
                r5_sq[i]  <= r_rs[4].rabs[i] * r_rs[4].rabs[i];
            end
            r2_border <= n_border;
            r_rs[3]   <= n_rs3;
            r_rs[4]   <= n_rs4;
            r_rs[5]   <= r_rs[4];
            r_rs[6]   <= r_rs[5];
            r6_ss     <= r5_sq[0] + r5_sq[1] + r5_sq[2];
        end
    end

    always_comb begin
        o_vld    = r_v[6];
        o_ss     = r6_ss;
        o_flags  = r_rs[6].flags;
        o_rneg   = r_rs[6].rneg;
        o_dep    = r_rs[6].dep;
        o_radius = r_c[6].rad;
        for (int c = 0; c < 3; c++) begin
            o_rabs[c] = r_rs[6].rabs[c];
            o_pos[c]  = r_rs[6].pos[c];
            o_nrm[c]  = r_rs[6].nrm[c];
        end
    end

endmodule

`default_nettype wire

// File: src/sbc_sqrt.sv
// Pipelined integer square root, two result bits per stage, with a side payload.
// Uses sbc_pkg for the operand widths.
`default_nettype none

module sbc_sqrt #(
    parameter int SW = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [sbc_pkg::SS_W-1:0]   i_x,
    input  logic [SW-1:0]              i_side,
    output logic                       o_vld,
    output logic [sbc_pkg::LEN_W-1:0]  o_root,
    output logic [SW-1:0]              o_side
);
    import sbc_pkg::*;

    localparam int NIT = SS_W / 2;
    localparam int PER = 2;
    localparam int NS  = (NIT + PER - 1) / PER;

    logic [NS:0]       r_v;
    logic [SS_W-1:0]   r_x   [NS+1];
    logic [SS_W-1:0]   r_res [NS+1];
    logic [SW-1:0]     r_sd  [NS+1];
    logic [SS_W-1:0]   n_x   [1:NS];
    logic [SS_W-1:0]   n_res [1:NS];

    always_comb begin
        logic [SS_W-1:0] tx;
        logic [SS_W-1:0] tr;
        logic [SS_W-1:0] bt;
        logic [SS_W:0]   t;
        for (int s = 1; s <= NS; s++) begin
            tx = r_x[s-1];
            tr = r_res[s-1];
            for (int j = 0; j < PER; j++) begin
                if ((s - 1) * PER + j < NIT) begin
                    bt = SS_W'(1) << (SS_W - 2 - 2 * ((s - 1) * PER + j));
                    t  = (SS_W + 1)'(tr) + (SS_W + 1)'(bt);
                    if ((SS_W + 1)'(tx) >= t) begin
                        tx = tx - t[SS_W-1:0];
                        tr = (tr >> 1) + bt;
                    end else begin
                        tr = tr >> 1;
                    end
                end
            end
            n_x[s]   = tx;
            n_res[s] = tr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= i_x;
            r_res[0] <= '0;
            r_sd[0]  <= i_side;
            for (int s = 1; s <= NS; s++) begin
                r_x[s]   <= n_x[s];
                r_res[s] <= n_res[s];
                r_sd[s]  <= r_sd[s-1];
            end
        end
    end

    assign o_vld  = r_v[NS];
    assign o_root = r_res[NS][LEN_W-1:0];
    assign o_side = r_sd[NS];

endmodule

`default_nettype wire

// File: src/sbc_div.sv
// Three-lane pipelined restoring divider for the normal, two quotient bits per
// stage, rounding half up; carries a side payload. Uses sbc_pkg.
`default_nettype none

module sbc_div #(
    parameter int SW = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [sbc_pkg::LEN_W-1:0]  i_a [3],
    input  logic [sbc_pkg::LEN_W-1:0]  i_den,
    input  logic [SW-1:0]              i_side,
    output logic                       o_vld,
    output logic [sbc_pkg::QUO_W-1:0]  o_q [3],
    output logic [SW-1:0]              o_side
);
    import sbc_pkg::*;

    localparam int PER = 2;
    localparam int NS  = (QUO_W + PER - 1) / PER;
    localparam int NW  = LEN_W + 14;

    logic [NS:0]        r_v;
    logic [LEN_W-1:0]   r_rem [NS+1][3];
    logic [QUO_W-1:0]   r_nb  [NS+1][3];
    logic [QUO_W-1:0]   r_q   [NS+1][3];
    logic [LEN_W-1:0]   r_den [NS+1];
    logic [SW-1:0]      r_sd  [NS+1];
    logic [LEN_W-1:0]   n_rem [1:NS][3];
    logic [QUO_W-1:0]   n_nb  [1:NS][3];
    logic [QUO_W-1:0]   n_q   [1:NS][3];
    logic [NW-1:0]      n_num [3];

    // Numerator a * 2^14 + den / 2
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_num[l] = {i_a[l], 14'd0} + NW'(i_den >> 1);
        end
    end

    always_comb begin
        logic [LEN_W-1:0] rm;
        logic [QUO_W-1:0] nb;
        logic [QUO_W-1:0] qq;
        logic [LEN_W:0]   t;
        for (int s = 1; s <= NS; s++) begin
            for (int l = 0; l < 3; l++) begin
                rm = r_rem[s-1][l];
                nb = r_nb[s-1][l];
                qq = r_q[s-1][l];
                for (int j = 0; j < PER; j++) begin
                    if ((s - 1) * PER + j < QUO_W) begin
                        t  = {rm, nb[QUO_W-1]};
                        nb = nb << 1;
                        if (t >= {1'b0, r_den[s-1]}) begin
                            t  = t - {1'b0, r_den[s-1]};
                            qq = {qq[QUO_W-2:0], 1'b1};
                        end else begin
                            qq = {qq[QUO_W-2:0], 1'b0};
                        end
                        rm = t[LEN_W-1:0];
                    end
                end
                n_rem[s][l] = rm;
                n_nb[s][l]  = nb;
                n_q[s][l]   = qq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            r_sd[0]  <= i_side;
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= LEN_W'(n_num[l][NW-1:QUO_W]);
                r_nb[0][l]  <= n_num[l][QUO_W-1:0];
                r_q[0][l]   <= '0;
            end
            for (int s = 1; s <= NS; s++) begin
                r_den[s] <= r_den[s-1];
                r_sd[s]  <= r_sd[s-1];
                for (int l = 0; l < 3; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_nb[s][l]  <= n_nb[s][l];
                    r_q[s][l]   <= n_q[s][l];
                end
            end
        end
    end

    always_comb begin
        o_vld  = r_v[NS];
        o_side = r_sd[NS];
        for (int l = 0; l < 3; l++) o_q[l] = r_q[NS][l];
    end

endmodule

`default_nettype wire

// File: src/sphere_box_contact.sv
// Sphere against oriented box contact test, fully pipelined streaming block.
// Depends on sbc_pkg, sbc_front, sbc_sqrt and sbc_div.
//
//  Channel   Direction  Transfer when               Content of tdata
//  i_s_*     in         i_s_tvalid & o_s_tready     sphere, radius, box centre, axes, half sizes
//  o_m_*     out        o_m_tvalid & i_m_tready     hit, contact point, normal, depth
//
// One transfer can be accepted on every clock while the output is not stalled; each
// input transfer yields exactly one result transfer after passing the 7 front
// stages, the square-root stages, the divider stages and the output register. All
// stages share one advance enable, so when the output register is full and not
// taken the whole pipeline holds and nothing is lost or repeated. Reset is
// synchronous, active low, and clears only the valid bits.
`default_nettype none

module sphere_box_contact #(
    parameter int COORD_WIDTH = 24,
    localparam int IN_RAW  = 6 * COORD_WIDTH + 228,
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW = 3 * COORD_WIDTH + 71,
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // From bit 0 up: sphere_center_x, _y, _z, sphere_radius, box_center_x, _y, _z,
    // box_axis_x_packed, box_axis_y_packed, box_axis_z_packed, box_half_sizes_packed
    input  logic [IN_W-1:0]   i_s_tdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // From bit 0 up: contact_hit, contact_pos_x, _y, _z, contact_normal_x, _y, _z,
    // contact_depth
    output logic [OUT_W-1:0]  o_m_tdata
);
    import sbc_pkg::*;

    localparam int CW = COORD_WIDTH;

    typedef struct packed {
        t_flags                 flags;
        logic [2:0]             rneg;
        logic [2:0][LEN_W-1:0]  rabs;
        logic [2:0][CW-1:0]     pos;
        logic [2:0][NRM_W-1:0]  nrm;
        logic [DEP_W-1:0]       dep;
        logic [HALF_W-1:0]      radius;
    } t_sq_side;

    typedef struct packed {
        logic                   hit;
        logic                   in_box;
        logic                   zlen;
        logic [2:0]             rneg;
        logic [2:0][CW-1:0]     pos;
        logic [2:0][NRM_W-1:0]  nrm;
        logic [DEP_W-1:0]       dep;
    } t_dv_side;

    // Shared advance: everything moves when the output register is free or taken.
    logic                     en;

    logic signed [CW-1:0]     in_sc [3];
    logic signed [CW-1:0]     in_bc [3];
    logic [47:0]              in_ax [3];

    logic                     fr_vld;
    logic [SS_W-1:0]          fr_ss;
    t_flags                   fr_flags;
    logic [LEN_W-1:0]         fr_rabs [3];
    logic [2:0]               fr_rneg;
    logic signed [CW-1:0]     fr_pos [3];
    logic signed [NRM_W-1:0]  fr_nrm [3];
    logic [DEP_W-1:0]         fr_dep;
    logic [HALF_W-1:0]        fr_radius;

    t_sq_side                 sq_in;
    t_sq_side                 sq_out;
    logic [$bits(t_sq_side)-1:0] sq_out_bits;
    logic                     sq_vld;
    logic [LEN_W-1:0]         sq_len;

    t_dv_side                 dv_in;
    t_dv_side                 dv_out;
    logic [$bits(t_dv_side)-1:0] dv_out_bits;
    logic [LEN_W-1:0]         dv_a [3];
    logic                     dv_vld;
    logic [QUO_W-1:0]         dv_q [3];

    logic                     r_vld;
    logic                     r_hit;
    logic [CW-1:0]            r_pos [3];
    logic [NRM_W-1:0]         r_nrm [3];
    logic [DEP_W-1:0]         r_dep;
    logic                     n_hit;
    logic [CW-1:0]            n_pos [3];
    logic [NRM_W-1:0]         n_nrm [3];
    logic [DEP_W-1:0]         n_dep;

    assign en         = !r_vld || i_m_tready;
    assign o_s_tready = en;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            in_sc[c] = $signed(i_s_tdata[CW*c +: CW]);
            in_bc[c] = $signed(i_s_tdata[3*CW + HALF_W + CW*c +: CW]);
            in_ax[c] = i_s_tdata[6*CW + HALF_W + 48*c +: 48];
        end
    end

    sbc_front #(.CW(CW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (i_s_tvalid),
        .i_sc     (in_sc),
        .i_bc     (in_bc),
        .i_radius (i_s_tdata[3*CW +: HALF_W]),
        .i_ax     (in_ax),
        .i_half   (i_s_tdata[6*CW + HALF_W + 144 +: 63]),
        .o_vld    (fr_vld),
        .o_ss     (fr_ss),
        .o_flags  (fr_flags),
        .o_rabs   (fr_rabs),
        .o_rneg   (fr_rneg),
        .o_pos    (fr_pos),
        .o_nrm    (fr_nrm),
        .o_dep    (fr_dep),
        .o_radius (fr_radius)
    );

    always_comb begin
        sq_in.flags  = fr_flags;
        sq_in.rneg   = fr_rneg;
        sq_in.dep    = fr_dep;
        sq_in.radius = fr_radius;
        for (int c = 0; c < 3; c++) begin
            sq_in.rabs[c] = fr_rabs[c];
            sq_in.pos[c]  = fr_pos[c];
            sq_in.nrm[c]  = fr_nrm[c];
        end
    end

    sbc_sqrt #(.SW($bits(t_sq_side))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (fr_vld),
        .i_x     (fr_ss),
        .i_side  (sq_in),
        .o_vld   (sq_vld),
        .o_root  (sq_len),
        .o_side  (sq_out_bits)
    );

    assign sq_out = t_sq_side'(sq_out_bits);

    // Hit decision: a centre in the box always hits; outside needs the radius to reach.
    always_comb begin
        dv_in.in_box = !sq_out.flags.border;
        dv_in.hit    = !sq_out.flags.border ||
                       (!sq_out.flags.far && LEN_W'(sq_out.radius) >= sq_len);
        dv_in.zlen   = sq_len == '0;
        dv_in.rneg   = sq_out.rneg;
        dv_in.pos    = sq_out.pos;
        dv_in.nrm    = sq_out.nrm;
        dv_in.dep    = sq_out.flags.border ?
                       DEP_W'(sq_out.radius) - DEP_W'(sq_len) : sq_out.dep;
        for (int c = 0; c < 3; c++) dv_a[c] = sq_out.rabs[c];
    end

    sbc_div #(.SW($bits(t_dv_side))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_a     (dv_a),
        .i_den   (sq_len),
        .i_side  (dv_in),
        .o_vld   (dv_vld),
        .o_q     (dv_q),
        .o_side  (dv_out_bits)
    );

    assign dv_out = t_dv_side'(dv_out_bits);

    // Final selection: a miss reports all zeros, a zero offset outside the box a zero normal.
    always_comb begin
        logic [NRM_W-1:0] n;
        n_hit = dv_out.hit;
        n_dep = dv_out.hit ? dv_out.dep : '0;
        for (int c = 0; c < 3; c++) begin
            n = (dv_q[c] > QUO_W'(Q14_ONE)) ? NRM_W'(Q14_ONE) : NRM_W'(dv_q[c]);
            if (dv_out.zlen) n = '0;
            if (dv_out.rneg[c]) n = -n;
            n_pos[c] = dv_out.hit ? dv_out.pos[c] : '0;
            if (!dv_out.hit)        n_nrm[c] = '0;
            else if (dv_out.in_box) n_nrm[c] = dv_out.nrm[c];
            else                    n_nrm[c] = n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= n_hit;
            r_dep <= n_dep;
            for (int c = 0; c < 3; c++) begin
                r_pos[c] <= n_pos[c];
                r_nrm[c] <= n_nrm[c];
            end
        end
    end

    assign o_m_tvalid = r_vld;
    assign o_m_tdata  = OUT_W'({r_dep, r_nrm[2], r_nrm[1], r_nrm[0],
                                r_pos[2], r_pos[1], r_pos[0], r_hit});

    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !r_hit) |-> (r_dep == '0 && r_nrm[0] == '0 && r_nrm[1] == '0 &&
                               r_nrm[2] == '0 && r_pos[0] == '0 && r_pos[1] == '0 &&
                               r_pos[2] == '0))
        else $error("miss result carries non-zero fields");

    a_normal_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> ($signed(r_nrm[0]) <= 16'sd16384 && $signed(r_nrm[0]) >= -16'sd16384 &&
                   $signed(r_nrm[1]) <= 16'sd16384 && $signed(r_nrm[1]) >= -16'sd16384 &&
                   $signed(r_nrm[2]) <= 16'sd16384 && $signed(r_nrm[2]) >= -16'sd16384))
        else $error("normal component out of range");

    a_ready_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_vld || i_m_tready) |-> o_s_tready)
        else $error("input stalled while output register is free");

endmodule

`default_nettype wire
